### rtl/whe_pkg.sv
package whe_pkg;

    localparam int DEF_HISTORY_DEPTH = 16;
    localparam int DEF_KIND_COUNT    = 7;

    localparam int KIND_W      = 3;
    localparam int STAMP_W     = 32;
    localparam int OUT_CNT_W   = 5;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // One history slot as it travels along the chain.
    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } bin_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

### rtl/whe_hist_cell.sv
module whe_hist_cell
    import whe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  entry_t d,
    output entry_t q
);

    logic               valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [STAMP_W-1:0] stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= d.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= d.kind;
            stamp_reg <= d.stamp;
        end
    end

    assign q = '{valid: valid_reg, kind: kind_reg, stamp: stamp_reg};

endmodule

### rtl/whe_bin_cell.sv
module whe_bin_cell
    import whe_pkg::*;
#(
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  bin_ctl_t         ctl,
    input  logic             hit,
    input  logic [CNT_W-1:0] d,
    output logic [CNT_W-1:0] q
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        priority if (ctl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctl.shift)
        begin
            cnt_next = d;
        end
        else if (hit)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    assign q = cnt_reg;

endmodule

### rtl/windowed_event_histogram.sv
// Windowed event histogram.
// Input stream (s_axis_*): tuser = 0 records an event (kind, stamp), tuser = 1
// queries the window. A record does not block the input, and the block
// takes the next item right after it. A record whose kind is KIND_COUNT or more
// is dropped. A query gives one result on the output stream (m_axis_*): the
// count of the queried kind, the total count and the most frequent kind among
// stored events whose age (now - stamp, mod 2^32) is at most the window.
// A query walks the history chain once, one slot per cycle, then shifts the
// kind bins past a compare, one kind per cycle, then loads the output register
// once that register is free. s_axis_tready is low while a query is worked on,
// so the block takes no new item until the query's result has been loaded
// into the output register.
// Reset empties the history (all valid bits clear) and drops any result.
// When the receiver stalls, the result holds in the output register; records
// are still taken, and a further query runs but waits to emit its result
// until the previous one has been transferred.
module windowed_event_histogram
    import whe_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int KIND_COUNT    = DEF_KIND_COUNT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] event_kind, [34:3] time_ms, [66:35] window_ms, [71:67] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [4:0] kind_count, [9:5] total_count, [12:10] dominant_kind, [15:13] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int WALK_W = $clog2(HISTORY_DEPTH);
    localparam int KIDX_W = $clog2(KIND_COUNT);

    // Unpack the input transfer.
    logic               action;
    logic [KIND_W-1:0]  in_kind;
    logic [STAMP_W-1:0] in_time;
    logic [STAMP_W-1:0] in_window;

    assign action    = s_axis_tuser;
    assign in_kind   = s_axis_tdata[2:0];
    assign in_time   = s_axis_tdata[34:3];
    assign in_window = s_axis_tdata[66:35];

    state_t state_reg;
    state_t state_next;

    logic in_xfer;
    logic rec_accept;
    logic qry_accept;
    logic walking;
    logic scanning;
    logic out_load;
    logic walk_last;
    logic scan_last;
    logic m_valid_reg;

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign rec_accept = in_xfer && (action == ACT_RECORD)
                        && ({{(32-KIND_W){1'b0}}, in_kind} < 32'(KIND_COUNT));
    assign qry_accept = in_xfer && (action == ACT_QUERY);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (qry_accept)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State decode.
    always_comb
    begin
        s_axis_tready = 1'b0;
        walking       = 1'b0;
        scanning      = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_WALK: walking       = 1'b1;
            ST_SCAN: scanning      = 1'b1;
            ST_EMIT: out_load      = !m_valid_reg || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold the query operands for the whole walk.
    logic [KIND_W-1:0]  q_kind_reg;
    logic [STAMP_W-1:0] q_now_reg;
    logic [STAMP_W-1:0] q_window_reg;

    always_ff @(posedge clk)
    begin
        if (qry_accept)
        begin
            q_kind_reg   <= in_kind;
            q_now_reg    <= in_time;
            q_window_reg <= in_window;
        end
    end

    // History chain: a record pushes a new slot in at the head and drops the
    // oldest off the tail; a walk rotates the ring once so every slot passes
    // the tail exactly once and lands back where it started.
    entry_t chain [HISTORY_DEPTH];
    entry_t tail;
    entry_t head_d;
    logic   chain_load;

    assign tail       = chain[HISTORY_DEPTH-1];
    assign chain_load = rec_accept || walking;

    always_comb
    begin
        if (walking)
        begin
            head_d = tail;
        end
        else
        begin
            head_d = '{valid: 1'b1, kind: in_kind, stamp: in_time};
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++)
        begin : g_hist
            if (gi == 0)
            begin : g_head
                whe_hist_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .load  (chain_load),
                    .d     (head_d),
                    .q     (chain[gi])
                );
            end
            else
            begin : g_body
                whe_hist_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .load  (chain_load),
                    .d     (chain[gi-1]),
                    .q     (chain[gi])
                );
            end
        end
    endgenerate

    // Window test on the tail slot; age wraps mod 2^32.
    logic [STAMP_W-1:0] age;
    logic               in_win;

    assign age    = q_now_reg - tail.stamp;
    assign in_win = walking && tail.valid && (age <= q_window_reg);

    logic [WALK_W-1:0] walk_cnt_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  match_reg;

    assign walk_last = walking && (walk_cnt_reg == WALK_W'(HISTORY_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_cnt_reg <= '0;
        end
        else if (qry_accept)
        begin
            walk_cnt_reg <= '0;
        end
        else if (walking)
        begin
            walk_cnt_reg <= walk_cnt_reg + WALK_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (qry_accept)
        begin
            total_reg <= '0;
            match_reg <= '0;
        end
        else if (in_win)
        begin
            total_reg <= total_reg + CNT_W'(1);
            if (tail.kind == q_kind_reg)
            begin
                match_reg <= match_reg + CNT_W'(1);
            end
        end
    end

    // Kind bins: count during the walk, then shift toward bin 0 for the scan.
    bin_ctl_t         bin_ctl;
    logic [CNT_W-1:0] bin_cnt [KIND_COUNT];

    assign bin_ctl = '{clear: qry_accept, shift: scanning};

    generate
        for (gi = 0; gi < KIND_COUNT; gi++)
        begin : g_bin
            logic hit;

            assign hit = in_win
                         && ({{(32-KIND_W){1'b0}}, tail.kind} == 32'(gi));

            if (gi == KIND_COUNT - 1)
            begin : g_last
                whe_bin_cell #(
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk (clk),
                    .ctl (bin_ctl),
                    .hit (hit),
                    .d   ('0),
                    .q   (bin_cnt[gi])
                );
            end
            else
            begin : g_body
                whe_bin_cell #(
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk (clk),
                    .ctl (bin_ctl),
                    .hit (hit),
                    .d   (bin_cnt[gi+1]),
                    .q   (bin_cnt[gi])
                );
            end
        end
    endgenerate

    // Scan: strict greater keeps the lowest kind on a tie, and kind 0 when
    // the window is empty.
    logic [KIDX_W-1:0] scan_cnt_reg;
    logic [KIDX_W-1:0] best_idx_reg;
    logic [CNT_W-1:0]  best_cnt_reg;

    assign scan_last = scanning && (scan_cnt_reg == KIDX_W'(KIND_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
        end
        else if (qry_accept)
        begin
            scan_cnt_reg <= '0;
        end
        else if (scanning)
        begin
            scan_cnt_reg <= scan_cnt_reg + KIDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (qry_accept)
        begin
            best_idx_reg <= '0;
            best_cnt_reg <= '0;
        end
        else if (scanning && (bin_cnt[0] > best_cnt_reg))
        begin
            best_idx_reg <= scan_cnt_reg;
            best_cnt_reg <= bin_cnt[0];
        end
    end

    // Output register: counts are reported modulo 32, the kind modulo 8.
    logic [31:0]            match_ext;
    logic [31:0]            total_ext;
    logic [31:0]            best_ext;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    assign match_ext = 32'(match_reg);
    assign total_ext = 32'(total_reg);
    assign best_ext  = 32'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= {3'b000, best_ext[KIND_W-1:0],
                           total_ext[OUT_CNT_W-1:0], match_ext[OUT_CNT_W-1:0]};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### rtl/whe_checker.sv
module whe_checker
    import whe_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready
);

    logic qry_xfer;
    logic rec_xfer;

    assign qry_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_QUERY);
    assign rec_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_RECORD);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A query occupies the block: no new item right after it.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        qry_xfer |=> !s_axis_tready)
        else $error("input ready right after a query");

    // A record never blocks the input.
    a_record_free: assert property (@(posedge clk) disable iff (!rst_n)
        rec_xfer |=> s_axis_tready)
        else $error("input blocked after a record");

    // A result never appears the cycle right after a query transfer.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(qry_xfer))
        else $error("result too early after query");

endmodule

bind windowed_event_histogram whe_checker u_whe_checker (.*);

### tb/whe_monitor.sv
module whe_monitor
    import whe_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int KIND_COUNT    = DEF_KIND_COUNT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] kind_count;
        logic [OUT_CNT_W-1:0] total_count;
        logic [KIND_W-1:0]    dominant_kind;
    } tally_t;

    logic [KIND_W-1:0]  kind_ring  [HISTORY_DEPTH];
    logic [STAMP_W-1:0] stamp_ring [HISTORY_DEPTH];
    int                 ring_ptr;
    int                 ring_fill;
    tally_t             expected_tallies[$];

    // Count the filled slots whose age falls inside the window.
    function automatic tally_t window_tally(logic [KIND_W-1:0] kind,
                                            logic [STAMP_W-1:0] now,
                                            logic [STAMP_W-1:0] span);
        tally_t             t;
        int                 hits [KIND_COUNT];
        int                 match;
        int                 total;
        int                 best;
        logic [STAMP_W-1:0] age;
        match = 0;
        total = 0;
        best  = 0;
        foreach (hits[k])
            hits[k] = 0;
        for (int i = 0; i < ring_fill; i++)
        begin
            age = now - stamp_ring[i];
            if (age <= span)
            begin
                total++;
                if (kind_ring[i] == kind)
                    match++;
                hits[kind_ring[i]]++;
            end
        end
        for (int k = 1; k < KIND_COUNT; k++)
            if (hits[k] > hits[best])
                best = k;
        t.kind_count    = match[OUT_CNT_W-1:0];
        t.total_count   = total[OUT_CNT_W-1:0];
        t.dominant_kind = best[KIND_W-1:0];
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tally_t             want;
        tally_t             got;
        logic [KIND_W-1:0]  in_kind;
        logic [STAMP_W-1:0] in_time;
        logic [STAMP_W-1:0] in_span;
        if (!rst_n)
        begin
            foreach (kind_ring[i])
            begin
                kind_ring[i]  = '0;
                stamp_ring[i] = '0;
            end
            ring_ptr   = 0;
            ring_fill  = 0;
            fail_count = 0;
            expected_tallies.delete();
            pending    = 0;
        end
        else
        begin
            // Check the outgoing transfer first; a result never belongs to
            // a query taken in the same cycle.
            if (m_tvalid && m_tready)
            begin
                got.kind_count    = m_tdata[4:0];
                got.total_count   = m_tdata[9:5];
                got.dominant_kind = m_tdata[12:10];
                if (expected_tallies.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result kind_count=%0d total_count=%0d",
                             $time, got.kind_count, got.total_count,
                             " dominant_kind=%0d", got.dominant_kind);
                end
                else
                begin
                    want = expected_tallies.pop_front();
                    if (got.kind_count !== want.kind_count)
                    begin
                        fail_count++;
                        $display("%0t: kind_count expected %0d actual %0d",
                                 $time, want.kind_count, got.kind_count);
                    end
                    if (got.total_count !== want.total_count)
                    begin
                        fail_count++;
                        $display("%0t: total_count expected %0d actual %0d",
                                 $time, want.total_count, got.total_count);
                    end
                    if (got.dominant_kind !== want.dominant_kind)
                    begin
                        fail_count++;
                        $display("%0t: dominant_kind expected %0d actual %0d",
                                 $time, want.dominant_kind, got.dominant_kind);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                in_kind = s_tdata[2:0];
                in_time = s_tdata[34:3];
                in_span = s_tdata[66:35];
                if (s_tuser == ACT_QUERY)
                    expected_tallies.push_back(window_tally(in_kind, in_time, in_span));
                else if (in_kind < KIND_COUNT)
                begin
                    kind_ring[ring_ptr]  = in_kind;
                    stamp_ring[ring_ptr] = in_time;
                    ring_ptr = (ring_ptr + 1) % HISTORY_DEPTH;
                    if (ring_fill < HISTORY_DEPTH)
                        ring_fill++;
                end
            end
            pending = expected_tallies.size();
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    import whe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_COUNT   = DEF_KIND_COUNT;
    localparam int RANDOM_ITEMS = 1600;
    // The limit is set well above both the time a query needs and the longest
    // receiver hold-off (HOLD_LEN), so that only a real hang trips it.
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_START   = 2000;
    localparam int HOLD_LEN     = 400;
    localparam int QUIET_FIRST  = 6000;
    localparam int QUIET_LAST   = 10000;
    localparam int DRAIN_CYCLES = 60;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    bit gaps_on = 1'b1;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    windowed_event_histogram u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        // [2:0] event_kind, [34:3] time_ms, [66:35] window_ms, [71:67] zero
        .s_axis_tdata  (s_tdata),
        // [0] action
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        // [4:0] kind_count, [9:5] total_count, [12:10] dominant_kind, [15:13] zero
        .m_axis_tdata  (m_tdata)
    );

    whe_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one item and hold it until the transfer happens. Called and
    // returns at a falling edge; valid is lowered only inside an idle gap,
    // so back-to-back items never see valid drop and rise in one step.
    task automatic offer_item(input logic act, input logic [KIND_W-1:0] kind,
                              input logic [STAMP_W-1:0] now,
                              input logic [STAMP_W-1:0] span);
        while (gaps_on && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, span, now, kind};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Receiver: random back-pressure, one long hold-off early on so that a
    // result sits in the output register while a further query waits to emit
    // its result, and a quiet stretch with tready held high.
    initial
    begin
        int cyc;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc == HOLD_START)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN - 1)
                    @(negedge clk);
                cyc += HOLD_LEN - 1;
            end
            else if (cyc >= QUIET_FIRST && cyc < QUIET_LAST)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 8);
        end
    end

    // Watchdog: end the run when no transfer happens on either side for
    // too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        logic [STAMP_W-1:0] ms_clock;
        logic [STAMP_W-1:0] now;
        logic [STAMP_W-1:0] span;
        logic [KIND_W-1:0]  kind;
        logic [KIND_W-1:0]  favored;
        int                 pick;

        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty window, out-of-range kinds, time wrap, zero and
        // full windows, stamps ahead of now, and a tie for most frequent.
        offer_item(ACT_QUERY,  3'd3, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_item(ACT_RECORD, 3'd7, 32'h0000_0005, 32'h1234_5678);
        offer_item(ACT_QUERY,  3'd7, 32'h0000_0005, 32'hFFFF_FFFF);
        offer_item(ACT_RECORD, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_item(ACT_RECORD, 3'd1, 32'hFFFF_FFF0, 32'h0000_0000);
        offer_item(ACT_RECORD, 3'd2, 32'h0000_0000, 32'h0000_0000);
        offer_item(ACT_RECORD, 3'd3, 32'h0000_000A, 32'h0000_0000);
        offer_item(ACT_RECORD, 3'd4, 32'h8000_0000, 32'h0000_0000);
        offer_item(ACT_RECORD, 3'd5, 32'h7FFF_FFFF, 32'h0000_0000);
        offer_item(ACT_RECORD, 3'd6, 32'h0000_0010, 32'h0000_0000);
        offer_item(ACT_QUERY,  3'd6, 32'h0000_0010, 32'h0000_0020);
        offer_item(ACT_QUERY,  3'd2, 32'h0000_0000, 32'h0000_0000);
        offer_item(ACT_QUERY,  3'd0, 32'h0000_0000, 32'h0000_000F);
        offer_item(ACT_QUERY,  3'd7, 32'h0000_0010, 32'hFFFF_FFFF);
        offer_item(ACT_QUERY,  3'd0, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_item(ACT_RECORD, 3'd5, 32'h0000_0020, 32'h0000_0000);
        offer_item(ACT_RECORD, 3'd3, 32'h0000_0020, 32'h0000_0000);
        offer_item(ACT_QUERY,  3'd5, 32'h0000_0020, 32'hFFFF_FFFF);
        offer_item(ACT_QUERY,  3'd3, 32'h8000_0000, 32'h7FFF_FFFF);

        // Random: mostly a steadily advancing clock with records and
        // queries whose windows cover part of the ring; some noise with
        // arbitrary stamps and windows, and jumps of the clock near wrap.
        ms_clock = $urandom();
        favored  = 3'($urandom_range(0, KIND_COUNT - 1));
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 700 && n < 1000);
            if ($urandom_range(0, 49) == 0)
                favored = 3'($urandom_range(0, KIND_COUNT - 1));
            if ($urandom_range(0, 199) == 0)
                ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 300);
            if ($urandom_range(0, 99) < 55)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    kind = 3'd7;
                else if (pick < 45)
                    kind = favored;
                else
                    kind = 3'($urandom_range(0, KIND_COUNT - 1));
                ms_clock += $urandom_range(0, 50);
                now = ($urandom_range(0, 99) < 85) ? ms_clock : $urandom();
                offer_item(ACT_RECORD, kind, now, $urandom());
            end
            else
            begin
                kind = 3'($urandom_range(0, 7));
                now  = ($urandom_range(0, 99) < 85) ? ms_clock + $urandom_range(0, 20)
                                                    : $urandom();
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    span = $urandom_range(0, 500);
                else if (pick < 60)
                    span = '0;
                else if (pick < 70)
                    span = '1;
                else
                    span = $urandom();
                offer_item(ACT_QUERY, kind, now, span);
            end
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every result, then give the block time to show
        // anything extra.
        wait (pending == 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/whe_pkg.sv
rtl/whe_hist_cell.sv
rtl/whe_bin_cell.sv
rtl/windowed_event_histogram.sv
rtl/whe_checker.sv
tb/whe_monitor.sv
tb/tb_top.sv
